// File: hdl/sm83s_pkg.sv
package sm83s_pkg;

    localparam logic [3:0] FLAG_Z = 4'b1000;
    localparam logic [3:0] FLAG_N = 4'b0100;
    localparam logic [3:0] FLAG_H = 4'b0010;
    localparam logic [3:0] FLAG_C = 4'b0001;

    localparam logic [2:0] STEP_RESET = 3'd0;
    localparam logic [2:0] STEP_DECODE = 3'd1;
    localparam logic [2:0] STEP_TWO = 3'd2;
    localparam logic [2:0] STEP_THREE = 3'd3;
    localparam logic [2:0] STEP_FOUR = 3'd4;
    localparam logic [2:0] STEP_FIVE = 3'd5;

    localparam logic [2:0] REG_HL_IND = 3'd6;
    localparam logic [2:0] REG_A = 3'd7;

    localparam logic [7:0] OP_NOP = 8'h00;
    localparam logic [7:0] OP_LD_A16_SP = 8'h08;
    localparam logic [7:0] OP_STOP = 8'h10;
    localparam logic [7:0] OP_JR_NZ = 8'h20;
    localparam logic [7:0] OP_JR_Z = 8'h28;
    localparam logic [7:0] OP_JR_NC = 8'h30;
    localparam logic [7:0] OP_JR_C = 8'h38;
    localparam logic [7:0] OP_LAST = 8'h4F;

    typedef struct packed {
        logic [7:0]  a;
        logic [3:0]  f;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
        logic [15:0] pc;
        logic [7:0]  op;
        logic [2:0]  step;
        logic [15:0] latch;
        logic        stopped;
    } core_state_t;

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  data;
        logic        active;
        logic        fetch;
    } bus_req_t;

endpackage

// File: hdl/sm83s_exec.sv
module sm83s_exec (
    input  sm83s_pkg::core_state_t cur,
    input  logic [7:0]             data,
    input  logic [15:0]            start_address,
    output sm83s_pkg::core_state_t nxt,
    output sm83s_pkg::bus_req_t    req
);

    function automatic logic [7:0] reg_get(input sm83s_pkg::core_state_t s,
                                           input logic [2:0] r);
        logic [7:0] v;
        begin
            case (r)
                3'd0: v = s.b;
                3'd1: v = s.c;
                3'd2: v = s.d;
                3'd3: v = s.e;
                3'd4: v = s.h;
                3'd5: v = s.l;
                3'd7: v = s.a;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    function automatic sm83s_pkg::core_state_t reg_set(input sm83s_pkg::core_state_t s,
                                                       input logic [2:0] r,
                                                       input logic [7:0] v);
        sm83s_pkg::core_state_t t;
        begin
            t = s;
            case (r)
                3'd0: t.b = v;
                3'd1: t.c = v;
                3'd2: t.d = v;
                3'd3: t.e = v;
                3'd4: t.h = v;
                3'd5: t.l = v;
                3'd7: t.a = v;
                default: t = s;
            endcase
            return t;
        end
    endfunction

    function automatic logic [15:0] pair_get(input sm83s_pkg::core_state_t s,
                                             input logic [1:0] k);
        logic [15:0] v;
        begin
            case (k)
                2'd0: v = {s.b, s.c};
                2'd1: v = {s.d, s.e};
                2'd2: v = {s.h, s.l};
                default: v = s.sp;
            endcase
            return v;
        end
    endfunction

    function automatic sm83s_pkg::core_state_t pair_set(input sm83s_pkg::core_state_t s,
                                                        input logic [1:0] k,
                                                        input logic [15:0] v);
        sm83s_pkg::core_state_t t;
        begin
            t = s;
            case (k)
                2'd0: {t.b, t.c} = v;
                2'd1: {t.d, t.e} = v;
                2'd2: {t.h, t.l} = v;
                default: t.sp = v;
            endcase
            return t;
        end
    endfunction

    // returns {flags, result}
    function automatic logic [11:0] inc_dec(input logic [7:0] v, input logic dec,
                                            input logic [3:0] f_in);
        logic [7:0] r;
        logic [3:0] f;
        begin
            r = dec ? v - 8'd1 : v + 8'd1;
            f = f_in & sm83s_pkg::FLAG_C;
            if (r == 8'd0) f = f | sm83s_pkg::FLAG_Z;
            if (dec) begin
                f = f | sm83s_pkg::FLAG_N;
                if (r[3:0] == 4'hF) f = f | sm83s_pkg::FLAG_H;
            end else if (r[3:0] == 4'h0) begin
                f = f | sm83s_pkg::FLAG_H;
            end
            return {f, r};
        end
    endfunction

    logic [2:0]  lo, r;
    logic        q;
    logic [1:0]  p;
    logic [11:0] idr;
    logic [15:0] hl, rr, tmp16, jr_off;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  aa;
    logic        cc, take;
    logic [1:0]  kk;

    always_comb
    begin
        nxt = cur;
        req = '0;
        lo = 3'd0; r = 3'd0; q = 1'b0; p = 2'd0;
        idr = '0; hl = '0; rr = '0; tmp16 = '0; jr_off = '0;
        sum17 = '0; sum13 = '0; aa = '0; cc = 1'b0; take = 1'b0; kk = 2'd0;
        if (cur.stopped) begin
            req = '0;
        end else if (cur.step == sm83s_pkg::STEP_RESET) begin
            nxt.pc = start_address + 16'd1;
            req.addr = start_address; req.active = 1'b1; req.fetch = 1'b1;
            nxt.step = sm83s_pkg::STEP_DECODE;
        end else if (cur.step == sm83s_pkg::STEP_DECODE) begin
            nxt.op = data;
            nxt.step = sm83s_pkg::STEP_TWO;
            lo = data[2:0]; q = data[3]; p = data[5:4]; r = data[5:3];
            // default for "fetch next" and "operand read" paths
            if (data > sm83s_pkg::OP_LAST) begin
                nxt.stopped = 1'b1;
            end else if (data[6]) begin
                if (lo == sm83s_pkg::REG_HL_IND) begin
                    req.addr = pair_get(cur, 2'd2); req.active = 1'b1;
                end else begin
                    nxt = reg_set(nxt, r, reg_get(cur, lo));
                    req.addr = cur.pc; req.active = 1'b1; req.fetch = 1'b1;
                    nxt.pc = cur.pc + 16'd1; nxt.step = sm83s_pkg::STEP_DECODE;
                end
            end else begin
                case (lo)
                    3'd0:
                    begin
                        req.addr = cur.pc; req.active = 1'b1; nxt.pc = cur.pc + 16'd1;
                        if (data == sm83s_pkg::OP_NOP || data == sm83s_pkg::OP_STOP) begin
                            req.fetch = 1'b1; nxt.step = sm83s_pkg::STEP_DECODE;
                        end
                    end
                    3'd1:
                    begin
                        if (!q) begin
                            req.addr = cur.pc; req.active = 1'b1; nxt.pc = cur.pc + 16'd1;
                        end else begin
                            hl = pair_get(cur, 2'd2);
                            rr = pair_get(cur, p);
                            sum17 = {1'b0, hl} + {1'b0, rr};
                            sum13 = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};
                            nxt.f = (cur.f & sm83s_pkg::FLAG_Z)
                                  | (sum13[12] ? sm83s_pkg::FLAG_H : 4'h0)
                                  | (sum17[16] ? sm83s_pkg::FLAG_C : 4'h0);
                            nxt = pair_set(nxt, 2'd2, sum17[15:0]);
                        end
                    end
                    3'd2:
                    begin
                        kk = (p < 2'd2) ? p : 2'd2;
                        tmp16 = pair_get(cur, kk);
                        if (p == 2'd2) nxt = pair_set(nxt, 2'd2, tmp16 + 16'd1);
                        if (p == 2'd3) nxt = pair_set(nxt, 2'd2, tmp16 - 16'd1);
                        req.addr = tmp16; req.active = 1'b1;
                        if (!q) begin
                            req.wr = 1'b1; req.data = cur.a;
                        end
                    end
                    3'd3:
                    begin
                        tmp16 = pair_get(cur, p);
                        nxt = pair_set(nxt, p, q ? tmp16 - 16'd1 : tmp16 + 16'd1);
                    end
                    3'd4, 3'd5:
                    begin
                        if (r == sm83s_pkg::REG_HL_IND) begin
                            req.addr = pair_get(cur, 2'd2); req.active = 1'b1;
                        end else begin
                            idr = inc_dec(reg_get(cur, r), lo[0], cur.f);
                            nxt.f = idr[11:8];
                            nxt = reg_set(nxt, r, idr[7:0]);
                            req.addr = cur.pc; req.active = 1'b1; req.fetch = 1'b1;
                            nxt.pc = cur.pc + 16'd1; nxt.step = sm83s_pkg::STEP_DECODE;
                        end
                    end
                    3'd6:
                    begin
                        req.addr = cur.pc; req.active = 1'b1; nxt.pc = cur.pc + 16'd1;
                    end
                    default:
                    begin
                        aa = cur.a; cc = cur.f[0];
                        case (r)
                            3'd0: begin nxt.a = {aa[6:0], aa[7]}; nxt.f = {3'b0, aa[7]}; end
                            3'd1: begin nxt.a = {aa[0], aa[7:1]}; nxt.f = {3'b0, aa[0]}; end
                            3'd2: begin nxt.a = {aa[6:0], cc}; nxt.f = {3'b0, aa[7]}; end
                            3'd3: begin nxt.a = {cc, aa[7:1]}; nxt.f = {3'b0, aa[0]}; end
                            3'd4:
                            begin
                                if (!cur.f[2]) begin
                                    if (cc || aa > 8'h99) begin
                                        aa = aa + 8'h60; cc = 1'b1;
                                    end
                                    if (cur.f[1] || aa[3:0] > 4'd9) aa = aa + 8'h06;
                                end else begin
                                    if (cc) aa = aa - 8'h60;
                                    if (cur.f[1]) aa = aa - 8'h06;
                                end
                                nxt.a = aa;
                                nxt.f = (cur.f & sm83s_pkg::FLAG_N)
                                      | ((aa == 8'h00) ? sm83s_pkg::FLAG_Z : 4'h0)
                                      | {3'b0, cc};
                            end
                            3'd5:
                            begin
                                nxt.a = ~aa;
                                nxt.f = cur.f | sm83s_pkg::FLAG_N | sm83s_pkg::FLAG_H;
                            end
                            3'd6: nxt.f = (cur.f & sm83s_pkg::FLAG_Z) | sm83s_pkg::FLAG_C;
                            default: nxt.f = (cur.f & sm83s_pkg::FLAG_Z) | {3'b0, ~cc};
                        endcase
                        req.addr = cur.pc; req.active = 1'b1; req.fetch = 1'b1;
                        nxt.pc = cur.pc + 16'd1; nxt.step = sm83s_pkg::STEP_DECODE;
                    end
                endcase
            end
        end else if (cur.step <= sm83s_pkg::STEP_FIVE) begin
            lo = cur.op[2:0]; q = cur.op[3]; p = cur.op[5:4]; r = cur.op[5:3];
            // default ending: next opcode fetch
            req.addr = cur.pc; req.active = 1'b1; req.fetch = 1'b1;
            nxt.pc = cur.pc + 16'd1; nxt.step = sm83s_pkg::STEP_DECODE;
            if (cur.op[6]) begin
                if (cur.step == sm83s_pkg::STEP_TWO) nxt = reg_set(nxt, r, data);
            end else if (cur.op == sm83s_pkg::OP_LD_A16_SP) begin
                if (cur.step == sm83s_pkg::STEP_TWO) begin
                    nxt.latch = {8'h00, data};
                    req.fetch = 1'b0; nxt.step = sm83s_pkg::STEP_THREE;
                end else if (cur.step == sm83s_pkg::STEP_THREE) begin
                    nxt.latch = {data, cur.latch[7:0]};
                    nxt.pc = cur.pc;
                    req = '0;
                    req.addr = {data, cur.latch[7:0]}; req.wr = 1'b1;
                    req.data = cur.sp[7:0]; req.active = 1'b1;
                    nxt.step = sm83s_pkg::STEP_FOUR;
                end else if (cur.step == sm83s_pkg::STEP_FOUR) begin
                    nxt.pc = cur.pc;
                    req = '0;
                    req.addr = cur.latch + 16'd1; req.wr = 1'b1;
                    req.data = cur.sp[15:8]; req.active = 1'b1;
                    nxt.step = sm83s_pkg::STEP_FIVE;
                end
            end else if (lo == 3'd0 && cur.step == sm83s_pkg::STEP_TWO) begin
                case (cur.op)
                    sm83s_pkg::OP_JR_NZ: take = !cur.f[3];
                    sm83s_pkg::OP_JR_Z:  take = cur.f[3];
                    sm83s_pkg::OP_JR_NC: take = !cur.f[0];
                    sm83s_pkg::OP_JR_C:  take = cur.f[0];
                    default: take = 1'b1;
                endcase
                if (take) begin
                    jr_off = {{8{data[7]}}, data};
                    nxt.pc = cur.pc + jr_off;
                    req = '0;
                    nxt.step = sm83s_pkg::STEP_THREE;
                end
            end else if (lo == 3'd1 && !q) begin
                if (cur.step == sm83s_pkg::STEP_TWO) begin
                    nxt.latch = {8'h00, data};
                    req.fetch = 1'b0; nxt.step = sm83s_pkg::STEP_THREE;
                end else if (cur.step == sm83s_pkg::STEP_THREE) begin
                    nxt = pair_set(nxt, p, {data, cur.latch[7:0]});
                end
            end else if (lo == 3'd2 && q && cur.step == sm83s_pkg::STEP_TWO) begin
                nxt.a = data;
            end else if ((lo == 3'd4 || lo == 3'd5) && r == sm83s_pkg::REG_HL_IND
                         && cur.step == sm83s_pkg::STEP_TWO) begin
                idr = inc_dec(data, lo[0], cur.f);
                nxt.f = idr[11:8];
                nxt.pc = cur.pc;
                req = '0;
                req.addr = {cur.h, cur.l}; req.wr = 1'b1; req.data = idr[7:0];
                req.active = 1'b1;
                nxt.step = sm83s_pkg::STEP_THREE;
            end else if (lo == 3'd6 && cur.step == sm83s_pkg::STEP_TWO) begin
                if (r == sm83s_pkg::REG_HL_IND) begin
                    nxt.pc = cur.pc;
                    req = '0;
                    req.addr = {cur.h, cur.l}; req.wr = 1'b1; req.data = data;
                    req.active = 1'b1;
                    nxt.step = sm83s_pkg::STEP_THREE;
                end else begin
                    nxt = reg_set(nxt, r, data);
                end
            end
        end else begin
            req.addr = cur.pc; req.active = 1'b1; req.fetch = 1'b1;
            nxt.pc = cur.pc + 16'd1; nxt.step = sm83s_pkg::STEP_DECODE;
        end
    end

endmodule

// File: hdl/eight_bit_cpu_core_subset_unit.sv
// SM83 core subset (opcodes 0x00-0x4F), one machine cycle per transaction. Each input
// transaction carries the byte read in the previous bus cycle; the matching output gives
// the next bus request and the register view. One transaction per clock is sustained while
// out_stall is low: the core state and the output register update in the same cycle from a
// single pass of decode/execute logic, and the output register holds a result while the
// consumer stalls. Results are valid in the cycle after input accept. start_address is sampled
// by the first transaction after reset. Undefined opcodes set bad_opcode and freeze the core.
module eight_bit_cpu_core_subset_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  read_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] bus_address,
    output logic        bus_is_write,
    output logic [7:0]  bus_write_data,
    output logic        bus_active,
    output logic        opcode_fetch,
    output logic        bad_opcode,
    output logic [15:0] view_af,
    output logic [15:0] view_bc,
    output logic [15:0] view_de,
    output logic [15:0] view_hl,
    output logic [15:0] view_sp,
    output logic [15:0] view_pc
);

    sm83s_pkg::core_state_t state_reg, state_next;
    sm83s_pkg::bus_req_t    req_next, req_reg;
    logic [15:0]            start_reg;
    logic                   valid_reg;
    logic                   accept;

    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    sm83s_exec u_exec (
        .cur           (state_reg),
        .data          (read_data),
        .start_address (start_reg),
        .nxt           (state_next),
        .req           (req_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= 16'h0100;
        end else if (cfg_we) begin
            start_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            // accumulator (top field) resets to 0x01, everything else to zero
            state_reg <= {8'h01, {($bits(sm83s_pkg::core_state_t) - 8){1'b0}}};
            valid_reg <= 1'b0;
            req_reg <= '0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                req_reg <= req_next;
                valid_reg <= 1'b1;
            end else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign bus_address    = req_reg.addr;
    assign bus_is_write   = req_reg.wr;
    assign bus_write_data = req_reg.data;
    assign bus_active     = req_reg.active;
    assign opcode_fetch   = req_reg.fetch;
    assign bad_opcode     = state_reg.stopped;
    assign view_af        = {state_reg.a, state_reg.f, 4'h0};
    assign view_bc        = {state_reg.b, state_reg.c};
    assign view_de        = {state_reg.d, state_reg.e};
    assign view_hl        = {state_reg.h, state_reg.l};
    assign view_sp        = state_reg.sp;
    assign view_pc        = state_reg.pc;

endmodule

// File: hdl/sm83s_checker.sv
module sm83s_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        bus_is_write,
    input logic        bus_active,
    input logic        opcode_fetch,
    input logic        bad_opcode,
    input logic [15:0] view_pc,
    input logic [15:0] bus_address
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_address))
        else $error("stalled result changed");

    a_write_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_is_write |-> bus_active && !opcode_fetch)
        else $error("write without active access");

    a_fetch_pc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opcode_fetch |-> view_pc == bus_address + 16'd1)
        else $error("fetch address does not match pc");

    a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_opcode |-> !bus_active)
        else $error("bus access after bad opcode");

endmodule

bind eight_bit_cpu_core_subset_unit sm83s_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bus_is_write (bus_is_write),
    .bus_active   (bus_active),
    .opcode_fetch (opcode_fetch),
    .bad_opcode   (bad_opcode),
    .view_pc      (view_pc),
    .bus_address  (bus_address)
);

// File: tb/sm83s_scoreboard.sv
`timescale 1ns / 100ps

module sm83s_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  read_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] bus_address,
    input  logic        bus_is_write,
    input  logic [7:0]  bus_write_data,
    input  logic        bus_active,
    input  logic        opcode_fetch,
    input  logic        bad_opcode,
    input  logic [15:0] view_af,
    input  logic [15:0] view_bc,
    input  logic [15:0] view_de,
    input  logic [15:0] view_hl,
    input  logic [15:0] view_sp,
    input  logic [15:0] view_pc,
    output int          errors,
    output int          pending,
    output logic        fetch_due
);

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  data;
        logic        active;
        logic        fetch;
        logic        bad;
        logic [15:0] af;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [15:0] pc;
    } cycle_result_t;

    cycle_result_t cycle_q[$];

    logic [15:0] start_addr;
    logic [7:0]  acc;
    logic [3:0]  flg;
    logic [7:0]  regs [0:5];
    logic [15:0] sp;
    logic [15:0] pc;
    logic [7:0]  opc;
    logic [2:0]  step;
    logic [15:0] latch;
    logic        halted;

    // pending bus request of the current machine cycle
    logic [15:0] rq_addr;
    logic        rq_wr;
    logic [7:0]  rq_data;
    logic        rq_active;
    logic        rq_fetch;

    assign pending = cycle_q.size();

    task automatic bus_idle();
        rq_addr = '0;
        rq_wr = 1'b0;
        rq_data = '0;
        rq_active = 1'b0;
        rq_fetch = 1'b0;
    endtask

    task automatic bus_read(input logic [15:0] a);
        bus_idle();
        rq_addr = a;
        rq_active = 1'b1;
    endtask

    task automatic bus_write(input logic [15:0] a, input logic [7:0] d);
        bus_idle();
        rq_addr = a;
        rq_wr = 1'b1;
        rq_data = d;
        rq_active = 1'b1;
    endtask

    task automatic read_operand();
        bus_read(pc);
        pc = pc + 16'd1;
    endtask

    task automatic fetch_next();
        read_operand();
        rq_fetch = 1'b1;
        step = sm83s_pkg::STEP_DECODE;
    endtask

    function automatic logic [15:0] pair_get(input logic [1:0] k);
        if (k == 2'd3)
            return sp;
        return {regs[{k, 1'b0}], regs[{k, 1'b1}]};
    endfunction

    task automatic pair_set(input logic [1:0] k, input logic [15:0] v);
        if (k == 2'd3)
            sp = v;
        else
        begin
            regs[{k, 1'b0}] = v[15:8];
            regs[{k, 1'b1}] = v[7:0];
        end
    endtask

    function automatic logic [7:0] reg_get(input logic [2:0] r);
        if (r == sm83s_pkg::REG_A)
            return acc;
        if (r < sm83s_pkg::REG_HL_IND)
            return regs[r];
        return 8'h00;
    endfunction

    task automatic reg_set(input logic [2:0] r, input logic [7:0] v);
        if (r == sm83s_pkg::REG_A)
            acc = v;
        else if (r < sm83s_pkg::REG_HL_IND)
            regs[r] = v;
    endtask

    // 8-bit INC/DEC; carry kept
    function automatic logic [7:0] step_incdec(input logic [7:0] v, input logic dec);
        logic [7:0] res;
        logic [3:0] f;
        res = dec ? v - 8'd1 : v + 8'd1;
        f = flg & sm83s_pkg::FLAG_C;
        if (res == 8'h00)
            f |= sm83s_pkg::FLAG_Z;
        if (dec)
        begin
            f |= sm83s_pkg::FLAG_N;
            if (res[3:0] == 4'hF)
                f |= sm83s_pkg::FLAG_H;
        end
        else if (res[3:0] == 4'h0)
            f |= sm83s_pkg::FLAG_H;
        flg = f;
        return res;
    endfunction

    task automatic accu_op(input logic [2:0] sel);
        logic [7:0] a;
        logic       c;
        a = acc;
        c = flg[0];
        case (sel)
            3'd0:
            begin
                acc = {a[6:0], a[7]};
                flg = {3'b000, a[7]};
            end
            3'd1:
            begin
                acc = {a[0], a[7:1]};
                flg = {3'b000, a[0]};
            end
            3'd2:
            begin
                acc = {a[6:0], c};
                flg = {3'b000, a[7]};
            end
            3'd3:
            begin
                acc = {c, a[7:1]};
                flg = {3'b000, a[0]};
            end
            3'd4:
            begin
                if ((flg & sm83s_pkg::FLAG_N) == 4'h0)
                begin
                    if (c || a > 8'h99)
                    begin
                        a = a + 8'h60;
                        c = 1'b1;
                    end
                    if ((flg & sm83s_pkg::FLAG_H) != 4'h0 || a[3:0] > 4'd9)
                        a = a + 8'h06;
                end
                else
                begin
                    if (c)
                        a = a - 8'h60;
                    if ((flg & sm83s_pkg::FLAG_H) != 4'h0)
                        a = a - 8'h06;
                end
                acc = a;
                flg = (flg & sm83s_pkg::FLAG_N) | ((a == 8'h00) ? sm83s_pkg::FLAG_Z : 4'h0)
                    | {3'b000, c};
            end
            3'd5:
            begin
                acc = ~a;
                flg = flg | sm83s_pkg::FLAG_N | sm83s_pkg::FLAG_H;
            end
            3'd6: flg = (flg & sm83s_pkg::FLAG_Z) | sm83s_pkg::FLAG_C;
            default: flg = (flg & sm83s_pkg::FLAG_Z) | {3'b000, ~c};
        endcase
    endtask

    task automatic decode_op(input logic [7:0] op);
        logic [2:0]  lo;
        logic        q;
        logic [1:0]  p;
        logic [2:0]  r;
        logic [15:0] hl;
        logic [15:0] rr;
        logic [16:0] sum;
        logic [12:0] half;
        logic [3:0]  f;
        logic [1:0]  k;
        logic [15:0] a;
        lo = op[2:0];
        q = op[3];
        p = op[5:4];
        r = op[5:3];
        step = sm83s_pkg::STEP_TWO;
        if (op > sm83s_pkg::OP_LAST)
        begin
            halted = 1'b1;
            bus_idle();
            return;
        end
        if (op >= 8'h40)
        begin
            if (lo == sm83s_pkg::REG_HL_IND)
                bus_read(pair_get(2'd2));
            else
            begin
                reg_set(r, reg_get(lo));
                fetch_next();
            end
            return;
        end
        case (lo)
            3'd0:
                if (op == sm83s_pkg::OP_NOP || op == sm83s_pkg::OP_STOP)
                    fetch_next();
                else
                    read_operand();
            3'd1:
                if (!q)
                    read_operand();
                else
                begin
                    hl = pair_get(2'd2);
                    rr = pair_get(p);
                    sum = {1'b0, hl} + {1'b0, rr};
                    half = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};
                    f = flg & sm83s_pkg::FLAG_Z;
                    if (half[12])
                        f |= sm83s_pkg::FLAG_H;
                    if (sum[16])
                        f |= sm83s_pkg::FLAG_C;
                    flg = f;
                    pair_set(2'd2, sum[15:0]);
                    bus_idle();
                end
            3'd2:
            begin
                k = (p < 2'd2) ? p : 2'd2;
                a = pair_get(k);
                if (p == 2'd2)
                    pair_set(2'd2, a + 16'd1);
                if (p == 2'd3)
                    pair_set(2'd2, a - 16'd1);
                if (!q)
                    bus_write(a, acc);
                else
                    bus_read(a);
            end
            3'd3:
            begin
                pair_set(p, q ? pair_get(p) - 16'd1 : pair_get(p) + 16'd1);
                bus_idle();
            end
            3'd4, 3'd5:
                if (r == sm83s_pkg::REG_HL_IND)
                    bus_read(pair_get(2'd2));
                else
                begin
                    reg_set(r, step_incdec(reg_get(r), lo == 3'd5));
                    fetch_next();
                end
            3'd6: read_operand();
            default:
            begin
                accu_op(r);
                fetch_next();
            end
        endcase
    endtask

    task automatic execute(input logic [7:0] d);
        logic [2:0] lo;
        logic       q;
        logic [1:0] p;
        logic [2:0] r;
        logic       take;
        lo = opc[2:0];
        q = opc[3];
        p = opc[5:4];
        r = opc[5:3];
        if (opc >= 8'h40)
        begin
            if (step == sm83s_pkg::STEP_TWO)
                reg_set(r, d);
            fetch_next();
            return;
        end
        if (opc == sm83s_pkg::OP_LD_A16_SP)
        begin
            case (step)
                sm83s_pkg::STEP_TWO:
                begin
                    latch = {8'h00, d};
                    read_operand();
                    step = sm83s_pkg::STEP_THREE;
                end
                sm83s_pkg::STEP_THREE:
                begin
                    latch = latch | {d, 8'h00};
                    bus_write(latch, sp[7:0]);
                    step = sm83s_pkg::STEP_FOUR;
                end
                sm83s_pkg::STEP_FOUR:
                begin
                    bus_write(latch + 16'd1, sp[15:8]);
                    step = sm83s_pkg::STEP_FIVE;
                end
                default: fetch_next();
            endcase
            return;
        end
        if (lo == 3'd0 && step == sm83s_pkg::STEP_TWO)
        begin
            case (opc)
                sm83s_pkg::OP_JR_NZ: take = (flg & sm83s_pkg::FLAG_Z) == 4'h0;
                sm83s_pkg::OP_JR_Z:  take = (flg & sm83s_pkg::FLAG_Z) != 4'h0;
                sm83s_pkg::OP_JR_NC: take = (flg & sm83s_pkg::FLAG_C) == 4'h0;
                sm83s_pkg::OP_JR_C:  take = (flg & sm83s_pkg::FLAG_C) != 4'h0;
                default:  take = 1'b1;
            endcase
            if (take)
            begin
                pc = pc + {{8{d[7]}}, d};
                bus_idle();
                step = sm83s_pkg::STEP_THREE;
                return;
            end
        end
        else if (lo == 3'd1 && !q)
        begin
            if (step == sm83s_pkg::STEP_TWO)
            begin
                latch = {8'h00, d};
                read_operand();
                step = sm83s_pkg::STEP_THREE;
                return;
            end
            if (step == sm83s_pkg::STEP_THREE)
                pair_set(p, {d, latch[7:0]});
        end
        else if (lo == 3'd2 && q && step == sm83s_pkg::STEP_TWO)
            acc = d;
        else if ((lo == 3'd4 || lo == 3'd5) && r == sm83s_pkg::REG_HL_IND
                 && step == sm83s_pkg::STEP_TWO)
        begin
            bus_write(pair_get(2'd2), step_incdec(d, lo == 3'd5));
            step = sm83s_pkg::STEP_THREE;
            return;
        end
        else if (lo == 3'd6 && step == sm83s_pkg::STEP_TWO)
        begin
            if (r == sm83s_pkg::REG_HL_IND)
            begin
                bus_write(pair_get(2'd2), d);
                step = sm83s_pkg::STEP_THREE;
                return;
            end
            reg_set(r, d);
        end
        fetch_next();
    endtask

    task automatic machine_cycle(input logic [7:0] d);
        if (halted)
            bus_idle();
        else if (step == sm83s_pkg::STEP_RESET)
        begin
            pc = start_addr;
            fetch_next();
        end
        else if (step == sm83s_pkg::STEP_DECODE)
        begin
            opc = d;
            decode_op(d);
        end
        else if (step <= sm83s_pkg::STEP_FIVE)
            execute(d);
        else
            fetch_next();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cycle_result_t want;
        if (!rst_n)
        begin
            errors = 0;
            start_addr = 16'h0100;
            acc = 8'h01;
            flg = 4'h0;
            for (int i = 0; i < 6; i++)
                regs[i] = 8'h00;
            sp = '0;
            pc = start_addr;
            opc = '0;
            step = sm83s_pkg::STEP_RESET;
            latch = '0;
            halted = 1'b0;
            bus_idle();
            fetch_due = 1'b0;
            cycle_q.delete();
        end
        else
        begin
            if (cfg_we)
                start_addr = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                if (cycle_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result transaction, address %h pc %h",
                             $time, bus_address, view_pc);
                end
                else
                begin
                    want = cycle_q.pop_front();
                    check_field("bus_address", want.addr, bus_address);
                    check_field("bus_is_write", 16'(want.wr), 16'(bus_is_write));
                    check_field("bus_write_data", 16'(want.data), 16'(bus_write_data));
                    check_field("bus_active", 16'(want.active), 16'(bus_active));
                    check_field("opcode_fetch", 16'(want.fetch), 16'(opcode_fetch));
                    check_field("bad_opcode", 16'(want.bad), 16'(bad_opcode));
                    check_field("view_af", want.af, view_af);
                    check_field("view_bc", want.bc, view_bc);
                    check_field("view_de", want.de, view_de);
                    check_field("view_hl", want.hl, view_hl);
                    check_field("view_sp", want.sp, view_sp);
                    check_field("view_pc", want.pc, view_pc);
                end
            end
            if (in_valid && !in_stall)
            begin
                machine_cycle(read_data);
                want.addr = rq_addr;
                want.wr = rq_wr;
                want.data = rq_data;
                want.active = rq_active;
                want.fetch = rq_fetch;
                want.bad = halted;
                want.af = {acc, flg, 4'h0};
                want.bc = pair_get(2'd0);
                want.de = pair_get(2'd1);
                want.hl = pair_get(2'd2);
                want.sp = sp;
                want.pc = pc;
                cycle_q.push_back(want);
                fetch_due = rq_fetch;
            end
        end
    end

endmodule

// File: tb/tb_eight_bit_cpu_core_subset_unit.sv
`timescale 1ns / 100ps

module tb_eight_bit_cpu_core_subset_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 460;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  read_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] bus_address;
    logic        bus_is_write;
    logic [7:0]  bus_write_data;
    logic        bus_active;
    logic        opcode_fetch;
    logic        bad_opcode;
    logic [15:0] view_af;
    logic [15:0] view_bc;
    logic [15:0] view_de;
    logic [15:0] view_hl;
    logic [15:0] view_sp;
    logic [15:0] view_pc;

    int   errors;
    int   pending;
    logic fetch_due;
    int   send_idle;
    int   recv_idle;
    int   cycles = 0;

    // opcodes and operand bytes of the directed program
    logic [7:0] dir_ops [$] = '{8'h08, 8'h3E, 8'h27, 8'h3C, 8'h27, 8'h2F, 8'h37, 8'h3F,
                                8'h07, 8'h0F, 8'h17, 8'h1F, 8'h05, 8'h39, 8'h20, 8'h38,
                                8'h18, 8'h10, 8'h4F, 8'h35};
    logic [7:0] dir_args [$] = '{8'hFF, 8'hFF, 8'h99, 8'h7F, 8'h80};

    eight_bit_cpu_core_subset_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .read_data(read_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bus_address(bus_address),
        .bus_is_write(bus_is_write),
        .bus_write_data(bus_write_data),
        .bus_active(bus_active),
        .opcode_fetch(opcode_fetch),
        .bad_opcode(bad_opcode),
        .view_af(view_af),
        .view_bc(view_bc),
        .view_de(view_de),
        .view_hl(view_hl),
        .view_sp(view_sp),
        .view_pc(view_pc)
    );

    sm83s_scoreboard u_scoreboard (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        read_data <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // a machine cycle with random content; opcodes stay in the implemented range
    task automatic send_random();
        logic [7:0] b;
        if (fetch_due)
            b = 8'($urandom_range(0, sm83s_pkg::OP_LAST));
        else if ($urandom_range(0, 9) == 0)
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
            b = 8'($urandom_range(0, 255));
        send_byte(b);
    endtask

    // write start_address once every result is in and the core has settled
    task automatic write_start(input logic [15:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        read_data = '0;
        send_idle = 21;
        recv_idle = 72;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_start(16'hFFFF);
        write_start(16'h0000);
        write_start(16'($urandom_range(0, 65535)));

        // first transaction: input byte is ignored
        send_byte(8'hFF);
        while (dir_ops.size() != 0)
        begin
            if (fetch_due)
                send_byte(dir_ops.pop_front());
            else if (dir_args.size() != 0)
                send_byte(dir_args.pop_front());
            else
                send_byte(8'h00);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle = 72;
                recv_idle = 21;
            end
            else if (ph == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_random();
            write_start(ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 65535)));
        end

        // unimplemented opcode freezes the core; later cycles must stay idle
        while (!fetch_due)
            send_random();
        send_byte(8'($urandom_range(sm83s_pkg::OP_LAST + 1, 255)));
        for (int i = 0; i < 12; i++)
            send_random();

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
